// File: rtl/illm_pkg.sv
// Shared types and codes for the linked list manager.
// No dependencies; compiled first.
`default_nettype none

package illm_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_ERASE = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_LINK  = 2'd2
    } t_status;

    localparam int IdW = 6;

endpackage

`default_nettype wire

// File: rtl/illm_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on illm_pkg for field widths.
`default_nettype none

interface illm_req_if;
    import illm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    logic [IdW-1:0]       node_id;

    modport source (output valid, output opcode, output node_id, input ready);
    modport sink   (input valid, input opcode, input node_id, output ready);
endinterface

interface illm_rsp_if;
    import illm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [IdW-1:0]       popped_node;
    logic                 popped_valid;
    logic [1:0]           status;
    logic                 list_empty;

    modport source (output valid, output popped_node, output popped_valid,
                    output status, output list_empty, input ready);
    modport sink   (input valid, input popped_node, input popped_valid,
                    input status, input list_empty, output ready);
endinterface

`default_nettype wire

// File: rtl/illm_link_ram.sv
// Link store: one write port, one registered read port with write bypass.
// No package dependencies.
`default_nettype none

module illm_link_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 7
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    logic [WIDTH-1:0] r_byp_data;
    logic             r_byp_hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata    <= r_mem[i_raddr];
            r_byp_hit  <= i_we && (i_waddr == i_raddr);
            r_byp_data <= i_wdata;
        end
    end

    assign o_rdata = r_byp_hit ? r_byp_data : r_rdata;

endmodule

`default_nettype wire

// File: rtl/intrusive_linked_list_manager_top.sv
// Doubly linked list over NODES slots: push at tail, pop from front, erase.
// Each accepted item is registered in stage 1; its result is registered when stage 1 fires.
// Throughput: one item per cycle while results are taken; the link RAM read at acceptance
// feeds the update logic of stage 1, with bypass of the write in flight.
// Reset (synchronous, active low) empties the list and clears all linked flags.
// Depends on illm_pkg, illm_if and illm_link_ram.
`default_nettype none

module intrusive_linked_list_manager_top
    import illm_pkg::*;
#(
    parameter int NODES = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    illm_req_if.sink   i_req,
    illm_rsp_if.source o_rsp
);
    localparam int LW = $clog2(NODES + 1);
    localparam int IW = $clog2(NODES);
    localparam logic [LW-1:0] SENT = LW'(NODES);

    logic [LW-1:0]    r_first, n_first;
    logic [LW-1:0]    r_tail, n_tail;
    logic [NODES-1:0] r_flag, n_flag;

    logic             r_s1_valid;
    t_opcode          r_s1_op;
    logic [LW-1:0]    r_s1_id;
    logic             r_s1_ok;

    logic             r_out_valid;
    logic [IdW-1:0]   r_popped;
    logic             r_pvalid;
    t_status          r_status;
    logic             r_empty;

    logic [IdW-1:0]   res_popped;
    logic             res_pvalid;
    t_status          res_status;

    logic             w_acc;
    logic             w_s1_fire;
    logic [LW-1:0]    w_in_id;
    logic [IW-1:0]    w_s1_idx;
    logic             w_flag;
    logic [LW-1:0]    w_next_q, w_prev_q;
    logic [LW-1:0]    w_p, w_x;

    logic             nxt_we, prv_we;
    logic [IW-1:0]    nxt_wa, prv_wa;
    logic [LW-1:0]    nxt_wd, prv_wd;
    logic [IW-1:0]    nxt_ra, prv_ra;

    assign w_s1_fire   = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || w_s1_fire;
    assign w_acc       = i_req.valid && i_req.ready;

    assign w_in_id  = LW'(i_req.node_id);
    assign w_s1_idx = r_s1_id[IW-1:0];
    assign w_flag   = r_s1_ok && r_flag[w_s1_idx];

    assign nxt_ra = (t_opcode'(i_req.opcode) == OP_POP) ? n_first[IW-1:0] : w_in_id[IW-1:0];
    assign prv_ra = w_in_id[IW-1:0];

    illm_link_ram #(.DEPTH(NODES), .WIDTH(LW)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_wa),
        .i_wdata (nxt_wd),
        .i_re    (w_acc),
        .i_raddr (nxt_ra),
        .o_rdata (w_next_q)
    );

    illm_link_ram #(.DEPTH(NODES), .WIDTH(LW)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prv_we),
        .i_waddr (prv_wa),
        .i_wdata (prv_wd),
        .i_re    (w_acc),
        .i_raddr (prv_ra),
        .o_rdata (w_prev_q)
    );

    always_comb begin
        n_first    = r_first;
        n_tail     = r_tail;
        n_flag     = r_flag;
        nxt_we     = 1'b0;
        nxt_wa     = '0;
        nxt_wd     = '0;
        prv_we     = 1'b0;
        prv_wa     = '0;
        prv_wd     = '0;
        res_popped = '0;
        res_pvalid = 1'b0;
        res_status = ST_OK;
        w_p        = (r_s1_id == r_first) ? SENT : w_prev_q;
        w_x        = (r_s1_id == r_tail) ? SENT : w_next_q;
        if (w_s1_fire) begin
            unique case (r_s1_op)
                OP_PUSH: begin
                    if (!r_s1_ok || w_flag) begin
                        res_status = ST_LINK;
                    end else begin
                        prv_we = 1'b1;
                        prv_wa = w_s1_idx;
                        prv_wd = r_tail;
                        if (r_tail == SENT) begin
                            n_first = r_s1_id;
                        end else begin
                            nxt_we = 1'b1;
                            nxt_wa = r_tail[IW-1:0];
                            nxt_wd = r_s1_id;
                        end
                        n_tail = r_s1_id;
                        n_flag[w_s1_idx] = 1'b1;
                    end
                end
                OP_POP: begin
                    if (r_first == SENT) begin
                        res_status = ST_EMPTY;
                    end else begin
                        w_x = (r_first == r_tail) ? SENT : w_next_q;
                        n_first = w_x;
                        if (w_x == SENT) begin
                            n_tail = SENT;
                        end
                        n_flag[r_first[IW-1:0]] = 1'b0;
                        res_popped = IdW'(r_first);
                        res_pvalid = 1'b1;
                    end
                end
                OP_ERASE: begin
                    if (!r_s1_ok || !w_flag) begin
                        res_status = ST_LINK;
                    end else begin
                        if (w_p == SENT) begin
                            n_first = w_x;
                        end else begin
                            nxt_we = 1'b1;
                            nxt_wa = w_p[IW-1:0];
                            nxt_wd = w_x;
                        end
                        if (w_x == SENT) begin
                            n_tail = w_p;
                        end else begin
                            prv_we = 1'b1;
                            prv_wa = w_x[IW-1:0];
                            prv_wd = w_p;
                        end
                        n_flag[w_s1_idx] = 1'b0;
                    end
                end
                OP_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= SENT;
            r_tail      <= SENT;
            r_flag      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_first <= n_first;
            r_tail  <= n_tail;
            r_flag  <= n_flag;
            if (w_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_op <= t_opcode'(i_req.opcode);
            r_s1_id <= w_in_id;
            r_s1_ok <= (32'(i_req.node_id) < NODES);
        end
        if (w_s1_fire) begin
            r_popped <= res_popped;
            r_pvalid <= res_pvalid;
            r_status <= res_status;
            r_empty  <= (n_first == SENT);
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.popped_node  = r_popped;
    assign o_rsp.popped_valid = r_pvalid;
    assign o_rsp.status       = r_status;
    assign o_rsp.list_empty   = r_empty;

    a_ends_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first == SENT) == (r_tail == SENT))
        else $error("head and tail disagree on empty list");

    a_head_linked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first != SENT) |-> r_flag[r_first[IW-1:0]])
        else $error("head node is not flagged as linked");

    a_tail_linked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail != SENT) |-> r_flag[r_tail[IW-1:0]])
        else $error("tail node is not flagged as linked");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pvalid) |-> (r_status == ST_OK))
        else $error("popped item carries an error status");

    a_empty_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first == SENT) |-> (r_flag == '0))
        else $error("empty list with linked nodes");

endmodule

`default_nettype wire

// File: verif/intrusive_linked_list_manager_top_test.sv
// Self-checking testbench for intrusive_linked_list_manager_top: push, pop and erase
// items against a linked-list predictor, with random idling and a long result stall.
// Depends on illm_pkg, illm_if and the RTL of the block.
`timescale 1ns / 100ps

module intrusive_linked_list_manager_top_test;
    import illm_pkg::*;

    localparam int NODES        = 64;
    localparam int RANDOM_ITEMS = 1250;
    localparam int PHASE_LEN    = 150;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [6:0] SENT = 7'(NODES);

    typedef struct packed {
        logic [IdW-1:0] popped_node;
        logic           popped_valid;
        t_status        status;
        logic           list_empty;
    } list_result_t;

    typedef struct {
        t_opcode        op;
        logic [IdW-1:0] id;
    } list_request_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    illm_req_if req_ch ();
    illm_rsp_if rsp_ch ();

    intrusive_linked_list_manager_top #(.NODES(NODES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predicted list state
    logic [6:0]       lst_first;
    logic [6:0]       lst_tail;
    logic [6:0]       lst_next [NODES];
    logic [6:0]       lst_prev [NODES];
    logic [NODES-1:0] lst_linked;

    // stimulus shadow of the list, in order
    logic [IdW-1:0]   gen_list [$];
    logic [NODES-1:0] gen_in;
    int               peak_depth;

    list_request_t pending [$];
    list_result_t  expected_results [$];
    list_request_t cur_req;
    list_result_t  got;
    list_result_t  want;

    int  errors;
    int  n_total;
    int  n_accepted;
    int  n_refused;
    int  n_by_op [4];
    bit  req_fire;
    int  gap_left;
    int  stall_left;
    int  hold_left;
    bit  held_once;
    wire quiet = (n_accepted + QUIET_TAIL >= n_total);

    function automatic void link_next(logic [6:0] idx, logic [6:0] v);
        if (idx == SENT) begin
            lst_first = v;
        end else begin
            lst_next[idx[IdW-1:0]] = v;
        end
    endfunction

    function automatic void link_prev(logic [6:0] idx, logic [6:0] v);
        if (idx == SENT) begin
            lst_tail = v;
        end else begin
            lst_prev[idx[IdW-1:0]] = v;
        end
    endfunction

    function automatic list_result_t apply_list_op(t_opcode op, logic [IdW-1:0] id);
        list_result_t r;
        logic [6:0]   p;
        logic [6:0]   x;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (int'(id) >= NODES || lst_linked[id]) begin
                    r.status = ST_LINK;
                end else begin
                    p = lst_tail;
                    lst_next[id] = SENT;
                    lst_prev[id] = p;
                    link_next(p, {1'b0, id});
                    lst_tail = {1'b0, id};
                    lst_linked[id] = 1'b1;
                end
            end
            OP_POP: begin
                if (lst_first == SENT) begin
                    r.status = ST_EMPTY;
                end else begin
                    p = lst_first;
                    x = lst_next[p[IdW-1:0]];
                    link_prev(x, SENT);
                    lst_first = x;
                    lst_linked[p[IdW-1:0]] = 1'b0;
                    r.popped_node = p[IdW-1:0];
                    r.popped_valid = 1'b1;
                end
            end
            OP_ERASE: begin
                if (int'(id) >= NODES || !lst_linked[id]) begin
                    r.status = ST_LINK;
                end else begin
                    p = lst_prev[id];
                    x = lst_next[id];
                    link_next(p, x);
                    link_prev(x, p);
                    lst_linked[id] = 1'b0;
                end
            end
            default: ;
        endcase
        r.list_empty = (lst_first == SENT);
        return r;
    endfunction

    task automatic add_item(t_opcode op, logic [IdW-1:0] id);
        list_request_t it;
        it.op = op;
        it.id = id;
        pending.push_back(it);
        case (op)
            OP_PUSH: begin
                if (!gen_in[id]) begin
                    gen_list.push_back(id);
                    gen_in[id] = 1'b1;
                end
            end
            OP_POP: begin
                if (gen_list.size() > 0) begin
                    gen_in[gen_list[0]] = 1'b0;
                    gen_list.delete(0);
                end
            end
            OP_ERASE: begin
                if (gen_in[id]) begin
                    gen_in[id] = 1'b0;
                    for (int k = 0; k < gen_list.size(); k++) begin
                        if (gen_list[k] == id) begin
                            gen_list.delete(k);
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (gen_list.size() > peak_depth) peak_depth = gen_list.size();
    endtask

    function automatic logic [IdW-1:0] rand_id();
        return IdW'($urandom_range(NODES - 1));
    endfunction

    // caller guarantees that a node of the wanted kind exists
    function automatic logic [IdW-1:0] pick_id(bit want_linked);
        logic [IdW-1:0] id;
        do begin
            id = rand_id();
        end while (gen_in[id] != want_linked);
        return id;
    endfunction

    // stimulus and end of run
    initial begin
        bit fill;
        int roll;
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_NOP;
        req_ch.node_id = '0;
        rsp_ch.ready = 1'b0;
        lst_first = SENT;
        lst_tail = SENT;
        lst_linked = '0;
        gen_in = '0;

        add_item(OP_POP, 6'd63);
        add_item(OP_ERASE, 6'd0);
        add_item(OP_NOP, 6'd0);
        add_item(OP_PUSH, 6'd0);
        add_item(OP_PUSH, 6'd0);
        add_item(OP_POP, 6'd0);
        add_item(OP_PUSH, 6'd63);
        add_item(OP_PUSH, 6'd0);
        add_item(OP_PUSH, 6'd42);
        add_item(OP_PUSH, 6'd21);
        add_item(OP_ERASE, 6'd42);
        add_item(OP_ERASE, 6'd21);
        add_item(OP_ERASE, 6'd63);
        add_item(OP_ERASE, 6'd0);
        add_item(OP_ERASE, 6'd0);
        add_item(OP_PUSH, 6'd5);
        add_item(OP_PUSH, 6'd6);
        add_item(OP_POP, 6'd63);
        add_item(OP_POP, 6'd0);
        add_item(OP_POP, 6'd42);
        add_item(OP_NOP, 6'd63);
        add_item(OP_PUSH, 6'd63);
        add_item(OP_ERASE, 6'd63);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            fill = ((i / PHASE_LEN) % 2) == 0;
            roll = $urandom_range(99);
            if (roll < 10) begin
                case ($urandom_range(2))
                    0: begin
                        if (gen_list.size() > 0) add_item(OP_PUSH, pick_id(1'b1));
                        else add_item(OP_POP, rand_id());
                    end
                    1: begin
                        if (gen_list.size() < NODES) add_item(OP_ERASE, pick_id(1'b0));
                        else add_item(OP_PUSH, rand_id());
                    end
                    default: add_item(OP_NOP, rand_id());
                endcase
            end else if (roll < (fill ? 80 : 25)) begin
                if (gen_list.size() < NODES) add_item(OP_PUSH, pick_id(1'b0));
                else add_item(OP_PUSH, rand_id());
            end else if (roll < (fill ? 90 : 60)) begin
                add_item(OP_POP, rand_id());
            end else begin
                if (gen_list.size() > 0) add_item(OP_ERASE, pick_id(1'b1));
                else add_item(OP_ERASE, rand_id());
            end
        end
        n_total = pending.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (!(n_accepted == n_total && expected_results.size() == 0)) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        $display("Ran %0d items: %0d push, %0d pop, %0d erase, %0d no-op; %0d refused.",
                 n_accepted, n_by_op[OP_PUSH], n_by_op[OP_POP], n_by_op[OP_ERASE],
                 n_by_op[OP_NOP], n_refused);
        $display("List depth reached %0d of %0d nodes; one result stall of %0d cycles.",
                 peak_depth, NODES, HOLD_CYCLES);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (req_fire || !req_ch.valid)) begin
            if (gap_left > 0) begin
                req_ch.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (!quiet && $urandom_range(7) == 0) begin
                req_ch.valid <= 1'b0;
                gap_left <= $urandom_range(10);
            end else if (pending.size() > 0) begin
                cur_req = pending.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.opcode <= cur_req.op;
                req_ch.node_id <= cur_req.id;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!held_once && n_accepted >= HOLD_AT) begin
            held_once <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
        end else if (quiet) begin
            rsp_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(7) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left <= $urandom_range(10);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // monitor: check results, then predict for the item taken at this edge
    always @(posedge i_clk) begin
        req_fire <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.popped_node = rsp_ch.popped_node;
                got.popped_valid = rsp_ch.popped_valid;
                got.status = t_status'(rsp_ch.status);
                got.list_empty = rsp_ch.list_empty;
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status != ST_OK) n_refused++;
                    if (got.popped_node !== want.popped_node) begin
                        $error("popped_node: expected %0d, got %0d",
                               want.popped_node, got.popped_node);
                        errors++;
                    end
                    if (got.popped_valid !== want.popped_valid) begin
                        $error("popped_valid: expected %0d, got %0d",
                               want.popped_valid, got.popped_valid);
                        errors++;
                    end
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        errors++;
                    end
                    if (got.list_empty !== want.list_empty) begin
                        $error("list_empty: expected %0d, got %0d",
                               want.list_empty, got.list_empty);
                        errors++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                expected_results.push_back(
                    apply_list_op(t_opcode'(req_ch.opcode), req_ch.node_id));
                n_by_op[req_ch.opcode]++;
                n_accepted++;
            end
        end
    end

endmodule
